@@ sv/tendon_wire_length_kinematics_assert.svh @@
// Assertion macros for the tendon wire length kinematics block.
// Used by the top level; no dependencies.
// Empty bodies when SYNTH is defined.
`ifndef TENDON_WIRE_LENGTH_KINEMATICS_ASSERT_SVH
`define TENDON_WIRE_LENGTH_KINEMATICS_ASSERT_SVH
`ifndef SYNTH
`define TWLK_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define TWLK_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define TWLK_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define TWLK_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

@@ sv/twlk_pkg.sv @@
// Package for the tendon wire length kinematics block: widths, CORDIC
// constants (built at elaboration), register indexes and reset values.
// No dependencies.
package twlk_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int MAX_STEPS    = 24;
    localparam int N_STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS :
                             (CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS;

    localparam int XW = 34;            // CORDIC x/y, Q.30
    localparam int ZW = 33;            // CORDIC angle, Q.29
    localparam int PW = XW + 17;       // bracket partial products, Q.45
    localparam int BW = PW + 2;        // bracket sums
    localparam int SW = BW - 23;       // bracket rounded to Q.22
    localparam int GW = 37;            // gain * 2 * radius * joints
    localparam int GL = 19;            // low slice of the gain product
    localparam int FW = SW + GW + 1;   // full product before wrap
    localparam int LW = 24;            // length width

    localparam logic signed [ZW-1:0] HALF_PI_Q29 = 33'sd843314857;
    localparam logic signed [ZW-1:0] PI_Q29      = 33'sd1686629713;

    typedef enum logic [2:0] {
        CFG_JOINT_COUNT = 3'd0,
        CFG_PITCH_RADIUS = 3'd1,
        CFG_COS_OFFSET  = 3'd2,
        CFG_SIN_OFFSET  = 3'd3,
        CFG_PULL_GAIN   = 3'd4,
        CFG_PUSH_GAIN   = 3'd5,
        CFG_COUPLING_GAIN = 3'd6
    } t_cfg_idx;

    localparam logic [3:0]  RST_JOINT_COUNT   = 4'd5;
    localparam logic [15:0] RST_PITCH_RADIUS  = 16'd6920;
    localparam logic [15:0] RST_COS_OFFSET    = 16'd32388;
    localparam logic [15:0] RST_SIN_OFFSET    = 16'd4972;
    localparam logic [15:0] RST_PULL_GAIN     = 16'd32768;
    localparam logic [15:0] RST_PUSH_GAIN     = 16'd29491;
    localparam logic [15:0] RST_COUPLING_GAIN = 16'd32768;

    // unsigned shift-subtract divide, used only for elaboration constants
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = 64'd0;
        rem = 65'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q.29, from a Q.60 series
    function automatic logic [63:0] atan_q29(input int i);
        logic [63:0] t;
        int          e;
        t = 64'd0;
        if (i == 0) begin
            t = 64'h0C90FDAA22168C23;
        end else begin
            for (int k = 0; k < 61; k++) begin
                e = i * (2 * k + 1);
                if (e <= 60) begin
                    if (k[0] == 1'b0) begin
                        t = t + udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
                    end else begin
                        t = t - udiv64(64'd1 << (60 - e), 64'(2 * k + 1));
                    end
                end
            end
        end
        return (t + (64'd1 << 30)) >> 31;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] b;
        p = v;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > p) b = b >> 2;
        while (b != 64'd0) begin
            if (p >= r + b) begin
                p = p - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // CORDIC gain compensation in Q.30
    function automatic logic [63:0] cordic_gain_q30(input int n);
        logic [63:0] p;
        logic [63:0] a;
        p = 64'd1 << 60;
        for (int i = 0; i < n; i++) p = p + (p >> (2 * i));
        a = isqrt64(p);
        return udiv64((64'd1 << 60) + (a >> 1), a);
    endfunction

endpackage

@@ sv/tendon_wire_length_kinematics.sv @@
// Throughput: one word per cycle; the whole pipeline advances together and
// holds when the output word is not taken.
// Reset (synchronous, active low) clears all valid bits and loads the
// configuration registers with their defaults. Config port is always ready.
// Depends on twlk_pkg and tendon_wire_length_kinematics_assert.svh.
`include "tendon_wire_length_kinematics_assert.svh"

module tendon_wire_length_kinematics
    import twlk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [15:0]   i_pan_angle,
    input  logic signed [15:0]   i_tilt_angle,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [LW-1:0] o_west_length,
    output logic signed [LW-1:0] o_east_length,
    output logic signed [LW-1:0] o_south_length,
    output logic signed [LW-1:0] o_north_length,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    localparam int NP = 7;  // stages after the CORDIC
    localparam logic signed [XW-1:0] ONE_Q30 = {{(XW-31){1'b0}}, 1'b1, 30'b0};
    localparam logic [63:0] K64 = cordic_gain_q30(N_STEPS);
    localparam logic signed [XW-1:0] K_Q30 = $signed(K64[XW-1:0]);

    // ---------------- configuration registers ----------------
    logic [3:0]  r_joint_count;
    logic [15:0] r_pitch_radius;
    logic [15:0] r_cos_offset;
    logic [15:0] r_sin_offset;
    logic [15:0] r_pull_gain;
    logic [15:0] r_push_gain;
    logic [15:0] r_coupling_gain;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_count   <= RST_JOINT_COUNT;
            r_pitch_radius  <= RST_PITCH_RADIUS;
            r_cos_offset    <= RST_COS_OFFSET;
            r_sin_offset    <= RST_SIN_OFFSET;
            r_pull_gain     <= RST_PULL_GAIN;
            r_push_gain     <= RST_PUSH_GAIN;
            r_coupling_gain <= RST_COUPLING_GAIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_JOINT_COUNT:   r_joint_count   <= i_cfg_data[3:0];
                CFG_PITCH_RADIUS:  r_pitch_radius  <= i_cfg_data;
                CFG_COS_OFFSET:    r_cos_offset    <= i_cfg_data;
                CFG_SIN_OFFSET:    r_sin_offset    <= i_cfg_data;
                CFG_PULL_GAIN:     r_pull_gain     <= i_cfg_data;
                CFG_PUSH_GAIN:     r_push_gain     <= i_cfg_data;
                CFG_COUPLING_GAIN: r_coupling_gain <= i_cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // Scale factors gain*2*radius*joints, refreshed every cycle in two registered steps;
    // the user must make config changes only while the pipe is empty; the block does not enforce it.
    logic [31:0]   r_pr_pull, r_pr_push;
    logic [GW-1:0] r_g_pull, r_g_push;

    always_ff @(posedge i_clk) begin
        r_pr_pull <= r_pull_gain * r_pitch_radius;
        r_pr_push <= r_push_gain * r_pitch_radius;
        r_g_pull  <= {36'(r_pr_pull * r_joint_count), 1'b0};
        r_g_push  <= {36'(r_pr_push * r_joint_count), 1'b0};
    end

    // ---------------- pipeline control ----------------
    logic            adv;
    logic [N_STEPS:0] r_cv;   // valid, fold stage and CORDIC stages
    logic [NP-1:0]   r_pv;    // valid, post stages

    assign adv         = !o_out_valid || i_out_ready;
    assign o_in_ready  = adv;
    assign o_out_valid = r_pv[NP-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
            r_pv <= '0;
        end else if (adv) begin
            r_cv <= {r_cv[N_STEPS-1:0], i_in_valid};
            r_pv <= {r_pv[NP-2:0], r_cv[N_STEPS]};
        end
    end

    // sign bits of the inputs travel with the word: [0] pan<0, [1] tilt<0
    logic [1:0] r_sg [N_STEPS+4];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sg[0] <= {i_tilt_angle[15], i_pan_angle[15]};
            for (int i = 1; i < N_STEPS + 4; i++) r_sg[i] <= r_sg[i-1];
        end
    end

    // ---------------- CORDIC, one rotation per stage, two lanes ----------------
    // lane 0 = pan/2, lane 1 = tilt/2
    logic signed [XW-1:0] r_x [2][N_STEPS+1];
    logic signed [XW-1:0] r_y [2][N_STEPS+1];
    logic signed [ZW-1:0] r_z [2][N_STEPS+1];
    logic                 r_neg [2][N_STEPS+1];

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [15:0]   ang;
        logic signed [ZW-1:0] z0;

        assign ang = (l == 0) ? i_pan_angle : i_tilt_angle;
        assign z0  = {{(ZW-31){ang[15]}}, ang, 15'b0};

        // fold into +/- pi/2, negating the results afterwards
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_x[l][0] <= K_Q30;
                r_y[l][0] <= '0;
                if (z0 > HALF_PI_Q29) begin
                    r_z[l][0]   <= z0 - PI_Q29;
                    r_neg[l][0] <= 1'b1;
                end else if (z0 < -HALF_PI_Q29) begin
                    r_z[l][0]   <= z0 + PI_Q29;
                    r_neg[l][0] <= 1'b1;
                end else begin
                    r_z[l][0]   <= z0;
                    r_neg[l][0] <= 1'b0;
                end
            end
        end

        for (genvar i = 0; i < N_STEPS; i++) begin : g_step
            localparam logic [63:0] ATAN64 = atan_q29(i);
            localparam logic signed [ZW-1:0] ATAN = $signed(ATAN64[ZW-1:0]);

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_neg[l][i+1] <= r_neg[l][i];
                    if (r_z[l][i] >= 0) begin
                        r_x[l][i+1] <= r_x[l][i] - (r_y[l][i] >>> i);
                        r_y[l][i+1] <= r_y[l][i] + (r_x[l][i] >>> i);
                        r_z[l][i+1] <= r_z[l][i] - ATAN;
                    end else begin
                        r_x[l][i+1] <= r_x[l][i] + (r_y[l][i] >>> i);
                        r_y[l][i+1] <= r_y[l][i] - (r_x[l][i] >>> i);
                        r_z[l][i+1] <= r_z[l][i] + ATAN;
                    end
                end
            end
        end
    end

    // ---------------- post stages ----------------
    logic signed [XW-1:0] r_s   [2];   // sin, Q.30
    logic signed [XW-1:0] r_omc [2];   // 1 - cos, Q.30
    logic signed [PW-1:0] r_pb  [2];   // cos_offset * (1 - cos)
    logic signed [PW-1:0] r_px  [2];   // sin_offset * sin
    logic signed [PW-1:0] r_pc  [2];   // coupling * (1 - cos)
    logic signed [BW-1:0] r_br  [4];   // brackets W, E, S, N in Q.45
    logic signed [SW-1:0] r_s22 [4];
    logic [GW-1:0]        r_g   [4];
    logic signed [SW+GL:0]      r_lo [4];
    logic signed [SW+GW-GL:0]   r_hi [4];
    logic signed [63:0]   r_prod [4];
    logic signed [LW-1:0] r_len [4];

    logic signed [16:0] ca_s, sa_s, cg_s;
    assign ca_s = $signed({1'b0, r_cos_offset});
    assign sa_s = $signed({1'b0, r_sin_offset});
    assign cg_s = $signed({1'b0, r_coupling_gain});

    // pull gain for W when pan>=0, E when pan<0, S when tilt>=0, N when tilt<0
    logic [3:0] use_pull;
    assign use_pull = {r_sg[N_STEPS+3][1], !r_sg[N_STEPS+3][1],
                       r_sg[N_STEPS+3][0], !r_sg[N_STEPS+3][0]};

    always_ff @(posedge i_clk) begin
        logic signed [XW-1:0] c;
        logic signed [BW-1:0] rb;
        logic signed [FW-1:0] full;
        logic signed [63:0]   rp;
        logic signed [63-37:0] um;
        if (adv) begin
            // 1: undo fold, form 1 - cos
            for (int l = 0; l < 2; l++) begin
                c = r_neg[l][N_STEPS] ? -r_x[l][N_STEPS] : r_x[l][N_STEPS];
                r_s[l]   <= r_neg[l][N_STEPS] ? -r_y[l][N_STEPS] : r_y[l][N_STEPS];
                r_omc[l] <= ONE_Q30 - c;
            end
            // 2: products
            for (int l = 0; l < 2; l++) begin
                r_pb[l] <= ca_s * r_omc[l];
                r_px[l] <= sa_s * r_s[l];
                r_pc[l] <= cg_s * r_omc[l];
            end
            // 3: brackets; cross-axis term uses the other lane
            r_br[0] <= BW'(r_pb[0]) - BW'(r_px[0]) + BW'(r_pc[1]);
            r_br[1] <= BW'(r_pb[0]) + BW'(r_px[0]) + BW'(r_pc[1]);
            r_br[2] <= BW'(r_pb[1]) - BW'(r_px[1]) + BW'(r_pc[0]);
            r_br[3] <= BW'(r_pb[1]) + BW'(r_px[1]) + BW'(r_pc[0]);
            // 4: round half up to Q.22, pick gain
            for (int w = 0; w < 4; w++) begin
                rb = r_br[w] + BW'(64'd1 << 22);
                r_s22[w] <= rb[BW-1:23];
                r_g[w]   <= use_pull[w] ? r_g_pull : r_g_push;
            end
            // 5: split multiply
            for (int w = 0; w < 4; w++) begin
                r_lo[w] <= r_s22[w] * $signed({1'b0, r_g[w][GL-1:0]});
                r_hi[w] <= r_s22[w] * $signed({1'b0, r_g[w][GW-1:GL]});
            end
            // 6: recombine, wrap to 64 bits
            for (int w = 0; w < 4; w++) begin
                full = (FW'(r_hi[w]) <<< GL) + FW'(r_lo[w]);
                r_prod[w] <= full[63:0];
            end
            // 7: round half up to micrometres, saturate
            for (int w = 0; w < 4; w++) begin
                rp = r_prod[w] + 64'sd68719476736;
                um = rp[63:37];
                if (um > 27'sd8388607) begin
                    r_len[w] <= 24'sh7FFFFF;
                end else if (um < -27'sd8388608) begin
                    r_len[w] <= 24'sh800000;
                end else begin
                    r_len[w] <= um[LW-1:0];
                end
            end
        end
    end

    assign o_west_length  = r_len[0];
    assign o_east_length  = r_len[1];
    assign o_south_length = r_len[2];
    assign o_north_length = r_len[3];

    // ---------------- assertions ----------------
    `TWLK_ASSERT_NXT(a_last_stage_fills, i_clk, i_rst_n, adv && r_pv[NP-2], o_out_valid)
    `TWLK_ASSERT_NXT(a_stall_keeps_valid, i_clk, i_rst_n, !adv && r_pv[NP-2], r_pv[NP-2])
    `TWLK_ASSERT_IMP(a_zero_joints, i_clk, i_rst_n, o_out_valid && r_joint_count == 4'd0 && r_g_pull == '0 && r_g_push == '0, o_west_length == '0 && o_north_length == '0)

endmodule
